[src/ddc_pkg.sv]
// Shared types and constants for the doorway direction counter.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package ddc_pkg;

	localparam int unsigned SLOT_PORTS   = 3;
	localparam int unsigned TARGET_SLOTS = 3;

	localparam int unsigned POS_W   = 15;
	localparam int unsigned THR_W   = 15;
	localparam int unsigned MISS_W  = 8;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned CFG_IW  = 3;
	localparam int unsigned CFG_DW  = 15;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_AREA_MIN_X = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_AREA_MAX_X = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_AREA_MIN_Y = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_AREA_MAX_Y = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_TRAVEL_THR = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_MISS_LIMIT = 3'd5;

	// reset values
	localparam logic signed [POS_W-1:0] RST_AREA_MIN = -15'sd16384;
	localparam logic signed [POS_W-1:0] RST_AREA_MAX = 15'sd16383;
	localparam logic [THR_W-1:0]        RST_TRAVEL   = 15'd1000;
	localparam logic [MISS_W-1:0]       RST_MISS_LIM = 8'd5;

	localparam logic [MISS_W-1:0]       MISS_MAX = 8'd255;
	localparam logic signed [CNT_W-1:0] OCC_MAX  = 16'sh7FFF;
	localparam logic signed [CNT_W-1:0] OCC_MIN  = 16'sh8000;
	localparam logic [CNT_W-1:0]        TOT_MAX  = 16'hFFFF;

	typedef struct packed {
		logic signed [POS_W-1:0] min_x;
		logic signed [POS_W-1:0] max_x;
		logic signed [POS_W-1:0] min_y;
		logic signed [POS_W-1:0] max_y;
		logic [THR_W-1:0]        travel;
		logic [MISS_W-1:0]       miss_limit;
	} cfg_t;

	typedef struct packed {
		logic                    valid;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} slot_in_t;

	// one crossing report from a slot tracker
	typedef struct packed {
		logic hit;
		logic up;
	} slot_evt_t;

	// step controls shared by the trackers and the tally
	typedef struct packed {
		logic adv;
		logic clr;
	} step_ctl_t;

endpackage

`default_nettype wire

[src/doorway_direction_counter.sv]
// Doorway direction counter top level: input register, slot trackers, tally.
// Depends on ddc_pkg, ddc_regs, ddc_slot and ddc_tally.
`timescale 1ns / 1ps
`default_nettype none

// One radar frame word in, one count word out, one frame per clock sustained
// while the output side does not stall. An accepted frame is held in the
// input register; once the result register is free or emptying, the slot
// trackers and the tally work on it and the updated counters land in the
// result register. The input register refills while a finished result
// waits, so a stall on the output side only stops intake once both registers
// are full. Slots are tracked in parallel; crossings found in one frame reach
// the counters in slot order, each saturating on its own. A clear word (cmd
// high) zeroes the counters and all slot state and returns the zeroed
// counters. Configuration writes are always taken (cfg_ready is tied high);
// indexes beyond the miss limit register are dropped.
module doorway_direction_counter #(
	parameter int unsigned TARGET_SLOTS = ddc_pkg::TARGET_SLOTS
) (
	input  wire                              clk,
	input  wire                              arst_n,

	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [ddc_pkg::CFG_IW-1:0]        cfg_index,
	input  wire [ddc_pkg::CFG_DW-1:0]        cfg_data,

	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              cmd,
	input  wire                              valid_0,
	input  wire signed [ddc_pkg::POS_W-1:0]  pos_x_0,
	input  wire signed [ddc_pkg::POS_W-1:0]  pos_y_0,
	input  wire                              valid_1,
	input  wire signed [ddc_pkg::POS_W-1:0]  pos_x_1,
	input  wire signed [ddc_pkg::POS_W-1:0]  pos_y_1,
	input  wire                              valid_2,
	input  wire signed [ddc_pkg::POS_W-1:0]  pos_x_2,
	input  wire signed [ddc_pkg::POS_W-1:0]  pos_y_2,

	output logic                             out_valid,
	input  wire                              out_ready,
	output logic signed [ddc_pkg::CNT_W-1:0] occupancy,
	output logic [ddc_pkg::CNT_W-1:0]        entry_total,
	output logic [ddc_pkg::CNT_W-1:0]        exit_total,
	output logic                             crossed
);
	import ddc_pkg::*;

	cfg_t       cfg;
	slot_in_t   in_slot  [SLOT_PORTS];
	slot_in_t   frame_s1 [TARGET_SLOTS];
	logic       cmd_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic       take;
	logic       fire;
	step_ctl_t  ctl;
	slot_evt_t  evt [TARGET_SLOTS];

	assign cfg_ready = 1'b1;

	ddc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign in_slot[0] = '{valid: valid_0, x: pos_x_0, y: pos_y_0};
	assign in_slot[1] = '{valid: valid_1, x: pos_x_1, y: pos_y_1};
	assign in_slot[2] = '{valid: valid_2, x: pos_x_2, y: pos_y_2};

	// advance the held frame whenever the result register is free or emptying
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)      valid_s1 <= 1'b1;
			else if (fire) valid_s1 <= 1'b0;
			if (fire)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// frame payload: no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
			for (int i = 0; i < TARGET_SLOTS; i++) frame_s1[i] <= in_slot[i];
		end
	end

	assign ctl.adv = fire && !cmd_s1;
	assign ctl.clr = fire && cmd_s1;

	for (genvar g = 0; g < TARGET_SLOTS; g++) begin : g_slot
		ddc_slot u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.cfg    (cfg),
			.tgt    (frame_s1[g]),
			.evt    (evt[g])
		);
	end

	ddc_tally #(
		.TARGET_SLOTS (TARGET_SLOTS)
	) u_tally (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.evt         (evt),
		.occupancy   (occupancy),
		.entry_total (entry_total),
		.exit_total  (exit_total),
		.crossed     (crossed)
	);

	assign out_valid = out_valid_q;

	// a processed frame always leaves a result behind
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed frame produced no result");

	// a clear word returns zeroed counters
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |=> (entry_total == '0) && (exit_total == '0)
			&& (occupancy == '0) && !crossed)
		else $error("clear left counters nonzero");

	// totals never drop on a normal frame
	a_totals_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv |=> (entry_total >= $past(entry_total))
			&& (exit_total >= $past(exit_total)))
		else $error("total decreased without clear");

	// counters stay put while no frame is processed
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(occupancy) && $stable(entry_total) && $stable(exit_total))
		else $error("counters moved without a frame");

endmodule

`default_nettype wire

[src/ddc_regs.sv]
// Configuration register file for the doorway direction counter.
// Depends on ddc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddc_regs (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        wr_en,
	input  wire [ddc_pkg::CFG_IW-1:0]  wr_index,
	input  wire [ddc_pkg::CFG_DW-1:0]  wr_data,
	output ddc_pkg::cfg_t              cfg
);
	import ddc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x      <= RST_AREA_MIN;
			cfg_q.max_x      <= RST_AREA_MAX;
			cfg_q.min_y      <= RST_AREA_MIN;
			cfg_q.max_y      <= RST_AREA_MAX;
			cfg_q.travel     <= RST_TRAVEL;
			cfg_q.miss_limit <= RST_MISS_LIM;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_AREA_MIN_X: cfg_q.min_x      <= wr_data;
				CFG_AREA_MAX_X: cfg_q.max_x      <= wr_data;
				CFG_AREA_MIN_Y: cfg_q.min_y      <= wr_data;
				CFG_AREA_MAX_Y: cfg_q.max_y      <= wr_data;
				CFG_TRAVEL_THR: cfg_q.travel     <= wr_data;
				CFG_MISS_LIMIT: cfg_q.miss_limit <= wr_data[MISS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/ddc_slot.sv]
// One target slot tracker: area test, displacement check, miss counting.
// Depends on ddc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddc_slot (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ddc_pkg::step_ctl_t   ctl,
	input  ddc_pkg::cfg_t        cfg,
	input  ddc_pkg::slot_in_t    tgt,
	output ddc_pkg::slot_evt_t   evt
);
	import ddc_pkg::*;

	logic                    active_q;
	logic                    counted_q;
	logic signed [POS_W-1:0] start_x_q;
	logic [MISS_W-1:0]       miss_q;

	logic                    in_box;
	logic signed [POS_W:0]   dx;
	logic [POS_W:0]          mag;
	logic                    far;
	logic [MISS_W-1:0]       miss_inc;

	always_comb begin
		in_box = tgt.valid && (tgt.x >= cfg.min_x) && (tgt.x <= cfg.max_x)
			&& (tgt.y >= cfg.min_y) && (tgt.y <= cfg.max_y);
		dx  = {tgt.x[POS_W-1], tgt.x} - {start_x_q[POS_W-1], start_x_q};
		mag = dx[POS_W] ? (~dx + 1'b1) : dx;
		far = mag >= {1'b0, cfg.travel};
		miss_inc = (miss_q == MISS_MAX) ? miss_q : miss_q + 1'b1;
		evt.hit = in_box && active_q && !counted_q && far;
		evt.up  = !dx[POS_W] && (dx != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			counted_q <= 1'b0;
			start_x_q <= '0;
			miss_q    <= '0;
		end else if (ctl.clr) begin
			active_q  <= 1'b0;
			counted_q <= 1'b0;
			start_x_q <= '0;
			miss_q    <= '0;
		end else if (ctl.adv) begin
			if (in_box) begin
				if (!active_q) begin
					active_q  <= 1'b1;
					counted_q <= 1'b0;
					start_x_q <= tgt.x;
					miss_q    <= '0;
				end else if (!counted_q) begin
					miss_q <= '0;
					if (far) counted_q <= 1'b1;
				end
			end else if (active_q) begin
				miss_q <= miss_inc;
				if (miss_inc >= cfg.miss_limit) active_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[src/ddc_tally.sv]
// Saturating occupancy, entry and exit counters; doubles as the result register.
// Depends on ddc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddc_tally #(
	parameter int unsigned TARGET_SLOTS = ddc_pkg::TARGET_SLOTS
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  ddc_pkg::step_ctl_t            ctl,
	input  ddc_pkg::slot_evt_t            evt [TARGET_SLOTS],
	output logic signed [ddc_pkg::CNT_W-1:0] occupancy,
	output logic [ddc_pkg::CNT_W-1:0]     entry_total,
	output logic [ddc_pkg::CNT_W-1:0]     exit_total,
	output logic                          crossed
);
	import ddc_pkg::*;

	logic signed [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0]        ent_q;
	logic [CNT_W-1:0]        ext_q;
	logic                    chg_q;

	logic signed [CNT_W-1:0] occ_d;
	logic [CNT_W-1:0]        ent_d;
	logic [CNT_W-1:0]        ext_d;
	logic                    chg_d;

	// apply slot crossings in slot order so saturation matches step by step
	always_comb begin
		occ_d = occ_q;
		ent_d = ent_q;
		ext_d = ext_q;
		chg_d = 1'b0;
		for (int i = 0; i < TARGET_SLOTS; i++) begin
			if (evt[i].hit) begin
				chg_d = 1'b1;
				if (evt[i].up) begin
					if (occ_d != OCC_MAX) occ_d = occ_d + 16'sd1;
					if (ent_d != TOT_MAX) ent_d = ent_d + 1'b1;
				end else begin
					if (occ_d != OCC_MIN) occ_d = occ_d - 16'sd1;
					if (ext_d != TOT_MAX) ext_d = ext_d + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			ent_q <= '0;
			ext_q <= '0;
			chg_q <= 1'b0;
		end else if (ctl.clr) begin
			occ_q <= '0;
			ent_q <= '0;
			ext_q <= '0;
			chg_q <= 1'b0;
		end else if (ctl.adv) begin
			occ_q <= occ_d;
			ent_q <= ent_d;
			ext_q <= ext_d;
			chg_q <= chg_d;
		end
	end

	assign occupancy   = occ_q;
	assign entry_total = ent_q;
	assign exit_total  = ext_q;
	assign crossed     = chg_q;

endmodule

`default_nettype wire

[sim/tb_doorway_direction_counter.sv]
// Self-checking testbench for the doorway direction counter.
// Depends on ddc_pkg and the doorway_direction_counter RTL; nothing else.
`timescale 1ns / 1ps

module tb_doorway_direction_counter;

	import ddc_pkg::*;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam int STALL_LIMIT  = 4000;   // cycles with no word moving while work is pending
	localparam int HOLD_CYCLES  = 300;    // long output hold-off that backs up the block
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 115;
	localparam int SWEEP_ROUNDS = 3;      // three one-step crossings per round
	localparam int SHOW_FAULTS  = 10;

	// one radar frame as offered on the input channel
	typedef struct packed {
		logic                          cmd;
		slot_in_t [SLOT_PORTS-1:0]     slot;
	} frame_t;

	// one counter word as returned on the output channel
	typedef struct packed {
		logic signed [CNT_W-1:0] occ;
		logic [CNT_W-1:0]        ent;
		logic [CNT_W-1:0]        ext;
		logic                    chg;
	} tally_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    cmd = 1'b0;
	logic                    valid_0 = 1'b0;
	logic signed [POS_W-1:0] pos_x_0 = '0;
	logic signed [POS_W-1:0] pos_y_0 = '0;
	logic                    valid_1 = 1'b0;
	logic signed [POS_W-1:0] pos_x_1 = '0;
	logic signed [POS_W-1:0] pos_y_1 = '0;
	logic                    valid_2 = 1'b0;
	logic signed [POS_W-1:0] pos_x_2 = '0;
	logic signed [POS_W-1:0] pos_y_2 = '0;

	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [CNT_W-1:0] occupancy;
	logic [CNT_W-1:0]        entry_total;
	logic [CNT_W-1:0]        exit_total;
	logic                    crossed;

	doorway_direction_counter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.valid_0     (valid_0),
		.pos_x_0     (pos_x_0),
		.pos_y_0     (pos_y_0),
		.valid_1     (valid_1),
		.pos_x_1     (pos_x_1),
		.pos_y_1     (pos_y_1),
		.valid_2     (valid_2),
		.pos_x_2     (pos_x_2),
		.pos_y_2     (pos_y_2),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.occupancy   (occupancy),
		.entry_total (entry_total),
		.exit_total  (exit_total),
		.crossed     (crossed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: configuration, per-slot trackers, counters
	// ------------------------------------------------------------------
	cfg_t box = '{RST_AREA_MIN, RST_AREA_MAX, RST_AREA_MIN, RST_AREA_MAX,
		RST_TRAVEL, RST_MISS_LIM};

	logic                    trk_active  [SLOT_PORTS];
	logic                    trk_counted [SLOT_PORTS];
	logic signed [POS_W-1:0] trk_start   [SLOT_PORTS];
	logic [MISS_W-1:0]       trk_miss    [SLOT_PORTS];
	int                      occ_now = 0;
	int                      ent_now = 0;
	int                      ext_now = 0;

	// stimulus and scoreboard storage
	frame_t frame_q [$];   // frames waiting to be offered
	tally_t tally_q [$];   // counter words owed by the block, oldest first
	frame_t shown;         // frame currently on the input port
	int     lane_x [SLOT_PORTS];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int frames_sent = 0;
	int tallies_checked = 0;
	int crossings_seen = 0;
	int settings_used = 0;
	int faults = 0;

	initial begin
		for (int s = 0; s < SLOT_PORTS; s++) begin
			trk_active[s]  = 1'b0;
			trk_counted[s] = 1'b0;
			trk_start[s]   = '0;
			trk_miss[s]    = '0;
		end
	end

	// Advance the shadow by one frame and return the counter word it owes.
	function automatic tally_t count_frame(frame_t f);
		tally_t r;
		int     xi;
		int     yi;
		int     dx;
		int     mag;
		logic   seen;
		r = '0;
		if (f.cmd == CMD_CLEAR) begin
			for (int s = 0; s < SLOT_PORTS; s++) begin
				trk_active[s]  = 1'b0;
				trk_counted[s] = 1'b0;
				trk_start[s]   = '0;
				trk_miss[s]    = '0;
			end
			occ_now = 0;
			ent_now = 0;
			ext_now = 0;
		end else begin
			for (int s = 0; s < TARGET_SLOTS; s++) begin
				xi = int'($signed(f.slot[s].x));
				yi = int'($signed(f.slot[s].y));
				seen = f.slot[s].valid &&
					xi >= $signed(box.min_x) && xi <= $signed(box.max_x) &&
					yi >= $signed(box.min_y) && yi <= $signed(box.max_y);
				if (seen) begin
					if (!trk_active[s]) begin
						// first sighting: arm the tracker at this x
						trk_active[s]  = 1'b1;
						trk_counted[s] = 1'b0;
						trk_start[s]   = f.slot[s].x;
						trk_miss[s]    = '0;
					end else if (!trk_counted[s]) begin
						dx  = xi - int'($signed(trk_start[s]));
						mag = (dx < 0) ? -dx : dx;
						trk_miss[s] = '0;
						if (mag >= int'(box.travel)) begin
							trk_counted[s] = 1'b1;
							r.chg = 1'b1;
							if (dx > 0) begin
								if (occ_now < int'(OCC_MAX)) occ_now++;
								if (ent_now < int'(TOT_MAX)) ent_now++;
							end else begin
								if (occ_now > int'(OCC_MIN)) occ_now--;
								if (ext_now < int'(TOT_MAX)) ext_now++;
							end
						end
					end
					// a counted slot seen again keeps everything, miss count too
				end else if (trk_active[s]) begin
					if (trk_miss[s] != MISS_MAX) trk_miss[s]++;
					if (trk_miss[s] >= box.miss_limit) trk_active[s] = 1'b0;
				end
			end
		end
		r.occ = occ_now[CNT_W-1:0];
		r.ent = ent_now[CNT_W-1:0];
		r.ext = ext_now[CNT_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic slot_in_t slot_of(logic v, int x, int y);
		slot_in_t t;
		t.valid = v;
		t.x = x[POS_W-1:0];
		t.y = y[POS_W-1:0];
		return t;
	endfunction

	function automatic frame_t frame_of(logic c, slot_in_t s0, slot_in_t s1, slot_in_t s2);
		frame_t f;
		f.cmd = c;
		f.slot[0] = s0;
		f.slot[1] = s1;
		f.slot[2] = s2;
		return f;
	endfunction

	// Uniform pick in [lo, hi]; an empty range yields any 15-bit position.
	function automatic int pick(int lo, int hi);
		if (hi < lo) return int'($urandom_range(32767)) - 16384;
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// Mostly targets walking along a lane inside the box, so trackers arm,
	// travel and count; the rest are dropouts and full-range noise.
	function automatic frame_t rand_frame();
		frame_t f;
		int     span;
		int     r;
		int     x;
		span = int'(box.travel) + int'(box.travel) / 2 + 64;
		f.cmd = ($urandom_range(99) < 2) ? CMD_CLEAR : CMD_FRAME;
		for (int s = 0; s < SLOT_PORTS; s++) begin
			if ($urandom_range(9) == 0)
				lane_x[s] = pick($signed(box.min_x), $signed(box.max_x));
			r = $urandom_range(99);
			if (r < 72) begin
				x = lane_x[s] + int'($urandom_range(2 * span)) - span;
				if (x > 16383) x = 16383;
				if (x < -16384) x = -16384;
				f.slot[s] = slot_of(1'b1, x, pick($signed(box.min_y), $signed(box.max_y)));
			end else if (r < 84) begin
				f.slot[s] = slot_of(1'b0, $urandom, $urandom);
			end else begin
				f.slot[s] = slot_of(1'($urandom_range(1)), $urandom, $urandom);
			end
		end
		return f;
	endfunction

	// Write one register and mirror it into the shadow once the word is taken.
	task automatic set_reg(logic [CFG_IW-1:0] idx, int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DW-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_AREA_MIN_X: box.min_x = val[POS_W-1:0];
			CFG_AREA_MAX_X: box.max_x = val[POS_W-1:0];
			CFG_AREA_MIN_Y: box.min_y = val[POS_W-1:0];
			CFG_AREA_MAX_Y: box.max_y = val[POS_W-1:0];
			CFG_TRAVEL_THR: box.travel = val[THR_W-1:0];
			CFG_MISS_LIMIT: box.miss_limit = val[MISS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_box(int min_x, int max_x, int min_y, int max_y, int thr, int miss);
		set_reg(CFG_AREA_MIN_X, min_x);
		set_reg(CFG_AREA_MAX_X, max_x);
		set_reg(CFG_AREA_MIN_Y, min_y);
		set_reg(CFG_AREA_MAX_Y, max_y);
		set_reg(CFG_TRAVEL_THR, thr);
		set_reg(CFG_MISS_LIMIT, miss);
		settings_used++;
	endtask

	task automatic random_setting();
		int lo_x;
		int lo_y;
		lo_x = pick(-16384, 8000);
		lo_y = pick(-16384, 8000);
		program_box(lo_x, lo_x + pick(0, 8383), lo_y, lo_y + pick(0, 8383),
			pick(0, 3000), pick(0, 8));
	endtask

	// Hold until every queued frame is taken and every owed word has come back.
	task automatic wait_idle();
		while (frame_q.size() != 0 || in_valid || tally_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: offer queued frames, predict each one as its word is taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic take;
		logic offer;
		take  = in_valid && in_ready;
		offer = in_valid && !take;   // hold the word until it is taken
		if (take) begin
			tally_q.push_back(count_frame(shown));
			frames_sent++;
		end
		if (!offer && frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			shown = frame_q.pop_front();
			cmd     <= shown.cmd;
			valid_0 <= shown.slot[0].valid;
			pos_x_0 <= shown.slot[0].x;
			pos_y_0 <= shown.slot[0].y;
			valid_1 <= shown.slot[1].valid;
			pos_x_1 <= shown.slot[1].x;
			pos_y_1 <= shown.slot[1].y;
			valid_2 <= shown.slot[2].valid;
			pos_x_2 <= shown.slot[2].x;
			pos_y_2 <= shown.slot[2].y;
			offer = 1'b1;
		end
		in_valid <= offer;
	end

	// ------------------------------------------------------------------
	// Monitor: check each counter word against the oldest owed one, and
	// drive out_ready (random stalls plus the occasional long hold-off)
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		tally_t want;
		logic   rdy;
		if (out_valid && out_ready) begin
			tallies_checked++;
			if (crossed) crossings_seen++;
			if (tally_q.size() == 0) begin
				faults++;
				if (faults <= SHOW_FAULTS)
					$display("ERROR: counter word with nothing owed: occ %0d ent %0d ext %0d chg %0b",
						occupancy, entry_total, exit_total, crossed);
			end else begin
				want = tally_q.pop_front();
				if (occupancy !== want.occ || entry_total !== want.ent ||
						exit_total !== want.ext || crossed !== want.chg) begin
					faults++;
					if (faults <= SHOW_FAULTS)
						$display("ERROR: word %0d: occ exp %0d got %0d, ent exp %0d got %0d, ext exp %0d got %0d, chg exp %0b got %0b",
							tallies_checked, want.occ, occupancy, want.ent, entry_total,
							want.ext, exit_total, want.chg, crossed);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (hold_seen != hold_req) begin
			// start a long hold-off so the block fills and stalls its input
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			rdy = 1'b0;
		end else begin
			rdy = ($urandom_range(99) >= recv_stall_pct);
		end
		out_ready <= rdy;
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run when no word moves for too long with work pending
	// ------------------------------------------------------------------
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else if (frame_q.size() != 0 || in_valid || tally_q.size() != 0 || cfg_valid)
				quiet++;
			else
				quiet = 0;
		end
		$display("ERROR: no progress for %0d cycles", STALL_LIMIT);
		$display("FAIL doorway_direction_counter");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequencer: reset, directed frames, crossing sweep, random phases
	// ------------------------------------------------------------------
	initial begin
		int dx;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: full box, threshold 1000, miss limit 5.
		// Clear with every field set: the fields must be ignored.
		frame_q.push_back(frame_of(CMD_CLEAR, slot_of(1'b1, 16383, 16383),
			slot_of(1'b1, -1, -1), slot_of(1'b1, -16384, -16384)));
		// arm all three slots, two of them at the box corners
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, -16384, -16384),
			slot_of(1'b1, 16383, 16383), slot_of(1'b1, 0, 0)));
		// full-width entry, full-width exit, short move that does not count
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, 16383, 0),
			slot_of(1'b1, -16384, 0), slot_of(1'b1, 500, 0)));
		// slot 0 missing, slot 1 counted and seen, slot 2 reaches the threshold
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b0, 16383, 0),
			slot_of(1'b1, 0, 0), slot_of(1'b1, 1000, 0)));
		// counted slot seen again keeps its miss count
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, 0, 0),
			slot_of(1'b0, 0, 0), slot_of(1'b0, 0, 0)));
		// run all slots out to their miss limit
		repeat (4) frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b0, 0, 0),
			slot_of(1'b0, 0, 0), slot_of(1'b0, 0, 0)));
		// re-arm slot 0 after the drop: counted flag and miss count reset
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, 100, 100),
			slot_of(1'b0, 0, 0), slot_of(1'b0, 0, 0)));
		frame_q.push_back(frame_of(CMD_CLEAR, slot_of(1'b0, 0, 0),
			slot_of(1'b0, 0, 0), slot_of(1'b0, 0, 0)));
		wait_idle();

		// Tiny box, zero threshold, zero miss limit: check the box edges,
		// a zero displacement counted as an exit, a drop on the first miss.
		program_box(-100, 100, -100, 100, 0, 0);
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, -100, -100),
			slot_of(1'b1, 101, 0), slot_of(1'b1, 0, -101)));
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, -100, 100),
			slot_of(1'b1, 100, 100), slot_of(1'b0, 0, 0)));
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, -100, 0),
			slot_of(1'b0, 100, 100), slot_of(1'b1, 0, 100)));
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b0, 0, 0),
			slot_of(1'b1, 100, 0), slot_of(1'b1, 0, 100)));
		wait_idle();

		// Empty box: minimum above maximum, nothing is ever inside.
		program_box(1, 0, 16383, -16384, 32767, 255);
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, 0, 0),
			slot_of(1'b1, 1, 0), slot_of(1'b1, 0, 16383)));
		frame_q.push_back(frame_of(CMD_CLEAR, slot_of(1'b0, 0, 0),
			slot_of(1'b0, 0, 0), slot_of(1'b0, 0, 0)));
		wait_idle();

		// Full box, largest threshold: only an edge-to-edge move counts.
		program_box(-16384, 16383, -16384, 16383, 32767, 255);
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, -16384, 5),
			slot_of(1'b1, 16383, -16384), slot_of(1'b1, 0, 0)));
		frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, 16383, 5),
			slot_of(1'b1, -16384, 16383), slot_of(1'b1, 16382, 0)));
		wait_idle();

		// Crossing sweep: arm, step one millimeter, drop, a few times over,
		// first entering on all slots at once, then exiting.
		program_box(-16384, 16383, -16384, 16383, 0, 0);
		frame_q.push_back(frame_of(CMD_CLEAR, slot_of(1'b0, 0, 0),
			slot_of(1'b0, 0, 0), slot_of(1'b0, 0, 0)));
		for (int dir = 0; dir < 2; dir++) begin
			dx = (dir == 0) ? 1 : -1;
			for (int k = 0; k < SWEEP_ROUNDS; k++) begin
				frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, 0, 0),
					slot_of(1'b1, 0, 7), slot_of(1'b1, 0, -7)));
				frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b1, dx, 0),
					slot_of(1'b1, dx, 7), slot_of(1'b1, dx, -7)));
				frame_q.push_back(frame_of(CMD_FRAME, slot_of(1'b0, dx, 0),
					slot_of(1'b0, 0, 0), slot_of(1'b0, 0, 0)));
			end
		end
		wait_idle();

		// Random phases: rotate the idle pattern and the box settings.
		for (int k = 0; k < RAND_PHASES; k++) begin
			case (k)
				0: program_box(-2000, 2000, -3000, 3000, 1000, 3);
				2: program_box(-16384, 16383, -16384, 16383, 0, 0);
				4: program_box(-16384, 16383, -16384, 16383, 32767, 255);
				5: program_box(pick(-16384, 0), pick(0, 16383), 100, -100, 500, 2);
				default: random_setting();
			endcase
			case (k % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			for (int s = 0; s < SLOT_PORTS; s++)
				lane_x[s] = pick($signed(box.min_x), $signed(box.max_x));
			// back the block up once while the sender keeps offering
			if (k == 0) hold_req++;
			repeat (PHASE_ITEMS) frame_q.push_back(rand_frame());
			wait_idle();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);

		$display("Covered %0d frames and %0d checked counter words over %0d box settings,",
			frames_sent, tallies_checked, settings_used);
		$display("with %0d crossing words, clears, box edges, idle and stall phases and a long hold-off.",
			crossings_seen);
		if (faults == 0 && tally_q.size() == 0) begin
			$display("PASS doorway_direction_counter");
		end else begin
			$display("ERROR: %0d mismatches, %0d words still owed", faults, tally_q.size());
			$display("FAIL doorway_direction_counter");
		end
		$finish;
	end

endmodule

[doorway_direction_counter.f]
src/ddc_pkg.sv
src/ddc_regs.sv
src/ddc_slot.sv
src/ddc_tally.sv
src/doorway_direction_counter.sv
sim/tb_doorway_direction_counter.sv
